>>> hw/rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_W       = 16;
    localparam int SUM_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET       = 16'hFFFF;
    localparam logic [15:0]      REPLACEMENT     = 16'hFFFD;
    localparam logic [20:0]      CODE_MAX        = 21'h10FFFF;
    localparam logic [20:0]      BMP_MAX         = 21'h00FFFF;
    localparam logic [20:0]      SUPP_BASE       = 21'h010000;
    localparam logic [20:0]      SURR_LO         = 21'h00D800;
    localparam logic [20:0]      SURR_HI         = 21'h00DFFF;
    localparam logic [5:0]       HI_SURR_TAG     = 6'b110110;
    localparam logic [5:0]       LO_SURR_TAG     = 6'b110111;

    // Final action of one byte, after any replacement words for a broken sequence
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CODE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  nrep;   // replacement words owed for a broken sequence
        kind_t       kind;
        logic        pair;   // code point needs a surrogate pair
        logic [15:0] w0;     // single word, or high surrogate
        logic [15:0] w1;     // low surrogate
    } entry_t;

endpackage

>>> hw/rtl/u8u16_front.sv
// Front end: byte decoder that turns UTF-8 bytes into word actions.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic [7:0]  in_byte,
    output logic        push,
    output entry_t      entry
);

    logic [20:0] acc_reg, acc_next;
    logic [2:0]  len_reg, len_next;
    logic [1:0]  taken_reg, taken_next;

    logic [20:0] acc_shift;
    logic [1:0]  taken_inc;
    logic [20:0] checked;
    logic [20:0] cp;
    logic [20:0] supp;
    logic [1:0]  nrep;
    kind_t       kind;
    logic        fresh;
    logic        is_cont;
    logic        pair;

    assign acc_shift = {acc_reg[14:0], in_byte[5:0]};
    assign taken_inc = taken_reg + 2'd1;
    assign is_cont   = (in_byte[7:6] == 2'b10);

    // Reject overlong forms, surrogates and values beyond the code space
    always_comb begin
        checked = acc_shift;
        if ((len_reg == 3'd2 && acc_shift <= 21'h7F) ||
            (len_reg == 3'd3 && acc_shift <= 21'h7FF) ||
            (len_reg == 3'd4 && acc_shift <= BMP_MAX) ||
            (acc_shift >= SURR_LO && acc_shift <= SURR_HI) ||
            (acc_shift > CODE_MAX)) begin
            checked = {5'd0, REPLACEMENT};
        end
    end

    always_comb begin
        acc_next   = acc_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        kind       = KIND_NONE;
        cp         = '0;
        nrep       = 2'd0;
        fresh      = 1'b1;
        if (len_reg != 3'd0) begin
            if (is_cont) begin
                fresh      = 1'b0;
                acc_next   = acc_shift;
                taken_next = taken_inc;
                if ({1'b0, taken_inc} >= len_reg || taken_inc == 2'd0) begin
                    kind       = KIND_CODE;
                    cp         = checked;
                    acc_next   = '0;
                    len_next   = 3'd0;
                    taken_next = 2'd0;
                end
            end else begin
                // broken sequence: owe one replacement per byte taken
                nrep       = taken_reg;
                acc_next   = '0;
                len_next   = 3'd0;
                taken_next = 2'd0;
            end
        end
        if (fresh) begin
            priority if (in_byte == 8'h00) begin
                kind = KIND_END;
            end else if (in_byte[7] == 1'b0) begin
                kind = KIND_CODE;
                cp   = {13'd0, in_byte};
            end else if (is_cont) begin
                kind = KIND_CODE;
                cp   = {5'd0, REPLACEMENT};
            end else if (in_byte[7:5] == 3'b110) begin
                acc_next   = {16'd0, in_byte[4:0]};
                len_next   = 3'd2;
                taken_next = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
                acc_next   = {17'd0, in_byte[3:0]};
                len_next   = 3'd3;
                taken_next = 2'd1;
            end else if (in_byte[7:3] == 5'b11110) begin
                acc_next   = {18'd0, in_byte[2:0]};
                len_next   = 3'd4;
                taken_next = 2'd1;
            end else begin
                kind = KIND_CODE;
                cp   = {5'd0, REPLACEMENT};
            end
        end
    end

    assign pair = (cp > BMP_MAX);
    assign supp = cp - SUPP_BASE;

    always_comb begin
        entry.nrep = nrep;
        entry.kind = kind;
        entry.pair = pair;
        entry.w0   = pair ? {HI_SURR_TAG, supp[19:10]} : cp[15:0];
        entry.w1   = {LO_SURR_TAG, supp[9:0]};
    end

    assign push = in_accept && ((nrep != 2'd0) || (kind != KIND_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            len_reg   <= '0;
            taken_reg <= '0;
        end else if (in_accept) begin
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
        end
    end

endmodule

>>> hw/rtl/u8u16_fifo.sv
// Short action queue between the decoder and the word emitter.
module u8u16_fifo
    import u8u16_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   not_full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head
);

    entry_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign not_full   = (count_reg != FCNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FCNT_W'(do_push) - FCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("push into a full queue");

endmodule

>>> hw/rtl/u8u16_back.sv
// Back end: word emitter with room check, word count and output register.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CAP_W-1:0] capacity,
    input  logic             head_valid,
    input  entry_t           head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   drop_reg, drop_next;
    logic [1:0]             rep_reg, rep_next;
    logic                   lo_reg, lo_next;
    logic                   out_valid_reg;
    logic [15:0]            word_reg, word_next;
    logic [15:0]            written_reg, written_next;
    logic                   term_reg, term_next;
    logic                   trunc_reg, trunc_next;

    logic                   slot_free, go, emit;
    logic                   is_rep, unit_active;
    logic [15:0]            unit_word;
    logic                   unit_pair;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   room_fail;

    assign slot_free = !out_valid_reg || m_tready;
    assign go        = head_valid && slot_free;
    assign count_inc = count_reg + 1'b1;
    assign is_rep    = !lo_reg && (rep_reg != head.nrep);
    assign unit_active = is_rep || (!lo_reg && head.kind == KIND_CODE);
    assign unit_word = is_rep ? REPLACEMENT : head.w0;
    assign unit_pair = is_rep ? 1'b0 : head.pair;
    assign room_fail = (SUM_W'(count_reg) + SUM_W'(unit_pair) + SUM_W'(2'd2))
                       > SUM_W'(capacity);

    always_comb begin
        count_next   = count_reg;
        drop_next    = drop_reg;
        rep_next     = rep_reg;
        lo_next      = lo_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        word_next    = '0;
        written_next = 16'(count_reg);
        term_next    = 1'b0;
        trunc_next   = 1'b0;
        if (go) begin
            // at most one code point per cycle through the room check, while the output slot is free
            if (unit_active && !drop_reg) begin
                if (room_fail) begin
                    emit       = (capacity != '0);
                    term_next  = 1'b1;
                    trunc_next = 1'b1;
                    drop_next  = 1'b1;
                end else begin
                    emit         = 1'b1;
                    word_next    = unit_word;
                    count_next   = count_inc;
                    written_next = 16'(count_inc);
                    lo_next      = unit_pair;
                end
            end
            priority if (lo_reg) begin
                emit         = 1'b1;
                word_next    = head.w1;
                count_next   = count_inc;
                written_next = 16'(count_inc);
                lo_next      = 1'b0;
                pop          = 1'b1;
                rep_next     = 2'd0;
            end else if (is_rep) begin
                rep_next = rep_reg + 2'd1;
                if ((rep_reg + 2'd1) == head.nrep && head.kind == KIND_NONE) begin
                    pop      = 1'b1;
                    rep_next = 2'd0;
                end
            end else begin
                unique case (head.kind)
                    KIND_CODE: begin
                        pop = !lo_next;
                    end
                    KIND_END: begin
                        emit       = !drop_reg && (capacity != '0);
                        term_next  = 1'b1;
                        count_next = '0;
                        drop_next  = 1'b0;
                        pop        = 1'b1;
                    end
                    default: begin
                        pop = 1'b1;
                    end
                endcase
                if (pop) begin
                    rep_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            rep_reg       <= '0;
            lo_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            rep_reg   <= rep_next;
            lo_reg    <= lo_next;
            if (slot_free) begin
                out_valid_reg <= go && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go && emit) begin
            word_reg    <= word_next;
            written_reg <= written_next;
            term_reg    <= term_next;
            trunc_reg   <= trunc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {written_reg, word_reg};
    assign m_tlast  = term_reg;
    assign m_tuser  = trunc_reg;

    a_lo_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg |-> head_valid)
        else $error("low surrogate pending without its queue entry");

    a_rep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && !lo_reg) |-> (rep_reg <= head.nrep))
        else $error("replacement count beyond owed number");

    a_trunc_on_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && word_reg == 16'h0000))
        else $error("truncation flag on a non-terminator word");

    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_reg && go && !lo_reg && head.kind != KIND_END) |=> !drop_reg || !$rose(m_tvalid))
        else $error("word emitted while dropping");

endmodule

>>> hw/rtl/utf8_to_utf16_transcoder.sv
// Top level of the streaming UTF-8 to UTF-16 transcoder.
//
// Input: one UTF-8 byte per s_ transaction; a zero byte ends the string.
// Output: one UTF-16 word per m_ transaction. m_tdata carries the word in
// [15:0] and the running count of non-terminator words in [31:16]; m_tlast
// marks the terminating zero word and m_tuser flags a terminator written
// because the destination capacity ran out.
// Configuration: cfg_wr_en writes cfg_wr_data as the capacity in words,
// terminator included; write it only while the block is idle.
// Path: with the queue empty and the output register free, the byte that
// completes a word goes into the action queue, then the output register.
// Throughput: one byte per cycle while each byte gives at most one word and
// m_tready is high. The emitter issues one word per cycle while m_tready
// allows; a byte that gives more words (surrogate pair, replacements for a
// broken sequence) holds it longer; a four-entry action queue absorbs this.
// Reset: clears the decoder, queue, word count and drop flag; capacity
// returns to 65535. No clearing pass is needed.
// Stall: the output register holds a word until m_tready; meanwhile bytes
// are still taken until the queue fills, then s_tready falls.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,    // capacity_words
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,        // [7:0] text_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,        // [15:0] utf16_word, [31:16] word_total
    output logic             m_tlast,        // is_terminator
    output logic             m_tuser         // [0] truncated
);

    logic [CAP_W-1:0] capacity_reg;
    logic             in_accept;
    logic             push;
    entry_t           push_entry;
    logic             not_full;
    logic             head_valid;
    entry_t           head;
    logic             pop;

    // Hold the capacity until the next configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Take a byte whenever the queue has room for its action
    assign s_tready  = not_full;
    assign in_accept = s_tvalid && not_full;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .push      (push),
        .entry     (push_entry)
    );

    u8u16_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    u8u16_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (capacity_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.

typedef struct packed {
    logic [15:0] word;
    logic        term;
    logic [15:0] count;
    logic        trunc;
} utf16_result_t;

// Predicts the UTF-16 words of the byte stream and checks what comes out.
class utf16_stream_check;
    bit [15:0]                        capacity;
    bit [20:0]                        code_acc;
    int                               seq_len;
    int                               taken;
    bit [u8u16_pkg::COUNT_WIDTH-1:0]  word_count;
    bit                               dropping;
    utf16_result_t                    pending_words[$];
    int                               errors;
    int                               words_seen;

    function new();
        capacity   = 16'hFFFF;
        code_acc   = '0;
        seq_len    = 0;
        taken      = 0;
        word_count = '0;
        dropping   = 1'b0;
        errors     = 0;
        words_seen = 0;
    endfunction

    function void report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endfunction

    function void set_capacity(bit [15:0] value);
        capacity = value;
    endfunction

    function int pending();
        return pending_words.size();
    endfunction

    function void push_word(bit [15:0] word, bit term, bit trunc);
        utf16_result_t r;
        r.word  = word;
        r.term  = term;
        r.count = word_count[15:0];
        r.trunc = trunc;
        pending_words.push_back(r);
    endfunction

    // Write one code point if it fits with the terminator, else truncate.
    function void emit_code_point(bit [20:0] cp);
        int        need;
        bit [20:0] v;
        if (dropping)
            return;
        need = (cp > 21'h00FFFF) ? 2 : 1;
        if (longint'(word_count) + need + 1 > longint'(capacity)) begin
            if (capacity != 0)
                push_word(16'h0000, 1'b1, 1'b1);
            dropping = 1'b1;
            return;
        end
        if (need == 1) begin
            word_count++;
            push_word(cp[15:0], 1'b0, 1'b0);
        end else begin
            v = cp - u8u16_pkg::SUPP_BASE;
            word_count++;
            push_word({u8u16_pkg::HI_SURR_TAG, v[19:10]}, 1'b0, 1'b0);
            word_count++;
            push_word({u8u16_pkg::LO_SURR_TAG, v[9:0]}, 1'b0, 1'b0);
        end
    endfunction

    // Byte seen with no sequence open.
    function void decode_fresh(bit [7:0] b);
        if (b == 8'h00) begin
            if (!dropping && capacity != 0)
                push_word(16'h0000, 1'b1, 1'b0);
            word_count = '0;
            dropping   = 1'b0;
            return;
        end
        if (dropping)
            return;
        if (b[7] == 1'b0) begin
            emit_code_point({13'b0, b});
        end else if (b[7:6] == 2'b10) begin
            emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
        end else if (b[7:5] == 3'b110) begin
            code_acc = {16'b0, b[4:0]};
            seq_len  = 2;
            taken    = 1;
        end else if (b[7:4] == 4'b1110) begin
            code_acc = {17'b0, b[3:0]};
            seq_len  = 3;
            taken    = 1;
        end else if (b[7:3] == 5'b11110) begin
            code_acc = {18'b0, b[2:0]};
            seq_len  = 4;
            taken    = 1;
        end else begin
            emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
        end
    endfunction

    function void take_byte(bit [7:0] b);
        bit [20:0] cp;
        int        owed;
        if (seq_len == 0) begin
            decode_fresh(b);
            return;
        end
        if (b[7:6] == 2'b10) begin
            code_acc = {code_acc[14:0], b[5:0]};
            taken++;
            if (taken >= seq_len) begin
                // overlong, surrogate and out-of-range forms collapse to one U+FFFD
                if ((seq_len == 2 && code_acc <= 21'h00007F) ||
                    (seq_len == 3 && code_acc <= 21'h0007FF) ||
                    (seq_len == 4 && code_acc <= u8u16_pkg::BMP_MAX) ||
                    (code_acc >= u8u16_pkg::SURR_LO && code_acc <= u8u16_pkg::SURR_HI) ||
                    code_acc > u8u16_pkg::CODE_MAX)
                    cp = {5'b0, u8u16_pkg::REPLACEMENT};
                else
                    cp = code_acc;
                seq_len  = 0;
                taken    = 0;
                code_acc = '0;
                emit_code_point(cp);
            end
            return;
        end
        // broken sequence: one replacement per byte taken, then start over
        owed     = taken;
        seq_len  = 0;
        taken    = 0;
        code_acc = '0;
        repeat (owed) emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
        decode_fresh(b);
    endfunction

    function void check_word(utf16_result_t got);
        utf16_result_t want;
        words_seen++;
        if (pending_words.size() == 0) begin
            report($sformatf("word %0d (%h) arrived with nothing expected",
                             words_seen, got.word));
            return;
        end
        want = pending_words.pop_front();
        if (got.word != want.word)
            report($sformatf("word %0d: utf16_word %h, expected %h",
                             words_seen, got.word, want.word));
        if (got.term != want.term)
            report($sformatf("word %0d: is_terminator %0d, expected %0d",
                             words_seen, got.term, want.term));
        if (got.count != want.count)
            report($sformatf("word %0d: word_total %0d, expected %0d",
                             words_seen, got.count, want.count));
        if (got.trunc != want.trunc)
            report($sformatf("word %0d: truncated %0d, expected %0d",
                             words_seen, got.trunc, want.trunc));
    endfunction

    function void drain();
        utf16_result_t want;
        while (pending_words.size() != 0) begin
            want = pending_words.pop_front();
            report($sformatf("expected word %h never arrived", want.word));
        end
    endfunction
endclass

module testbench;
    import u8u16_pkg::*;

    // Receiver back-pressure patterns
    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = 8'h00;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [31:0]      m_tdata;      // [15:0] utf16_word, [31:16] word_total
    logic             m_tlast;      // is_terminator
    logic             m_tuser;      // [0] truncated

    utf16_stream_check utf16_check;
    bit [7:0]          text_q[$];
    rx_mode_t          rx_mode    = RX_FREE;
    bit                tx_gaps    = 1'b0;
    int                rx_tick    = 0;
    int                idle_cycles = 0;

    utf8_to_utf16_transcoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: hold m_tready to the current stall pattern, updated on the falling edge.
    always @(negedge aclk) begin
        rx_tick++;
        case (rx_mode)
            RX_FREE:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 9) >= 3);
            RX_PERIODIC: m_tready <= ((rx_tick % 7) >= 3);
            default:     m_tready <= ((rx_tick % 40) < 26);
        endcase
    end

    // Monitor: note register writes and input transactions before checking outputs,
    // all on pre-edge values sampled at the rising edge.
    always @(posedge aclk) begin
        utf16_result_t got;
        if (aresetn) begin
            if (cfg_wr_en)
                utf16_check.set_capacity(cfg_wr_data);
            if (s_tvalid && s_tready)
                utf16_check.take_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got.word  = m_tdata[15:0];
                got.count = m_tdata[31:16];
                got.term  = m_tlast;
                got.trunc = m_tuser;
                utf16_check.check_word(got);
            end
        end
    end

    // Watchdog: count cycles without any transaction; a stuck block ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Append the UTF-8 encoding of cp in len bytes; high bits beyond len are dropped,
    // which gives overlong forms when cp is small.
    task automatic put_code(input bit [20:0] cp, input int len);
        case (len)
            1: text_q.push_back(cp[7:0]);
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed characters, the rest malformed on purpose.
    task automatic add_char();
        int        sel;
        int        len;
        bit [20:0] cp;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            put_code(21'($urandom_range(1, 'h7F)), 1);
        end else if (sel < 45) begin
            put_code(21'($urandom_range('h80, 'h7FF)), 2);
        end else if (sel < 60) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI)
                cp = cp ^ 21'h003000;    // move out of the surrogate range
            put_code(cp, 3);
        end else if (sel < 73) begin
            put_code(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end else if (sel < 78) begin
            len = $urandom_range(2, 4);
            case (len)
                2:       put_code(21'($urandom_range(0, 'h7F)), 2);
                3:       put_code(21'($urandom_range(0, 'h7FF)), 3);
                default: put_code(21'($urandom_range(0, 'hFFFF)), 4);
            endcase
        end else if (sel < 82) begin
            put_code(21'($urandom_range('hD800, 'hDFFF)), 3);
        end else if (sel < 85) begin
            put_code(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end else if (sel < 92) begin
            // cut a sequence short so that the next byte breaks it
            len = $urandom_range(2, 4);
            put_code(21'($urandom_range(0, 'h1FFFFF)), len);
            repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
        end else begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    // Queue whole strings until about n_bytes are waiting; optionally drop the last
    // NUL so that the next register write lands mid-string.
    task automatic add_text(input int n_bytes, input bit leave_open);
        int target;
        int len;
        target = text_q.size() + n_bytes;
        while (text_q.size() < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
            repeat (len) add_char();
            text_q.push_back(8'h00);
        end
        if (leave_open)
            void'(text_q.pop_back());
    endtask

    // Sender: drive queued bytes in bursts of random length, gaps between bursts when tx_gaps is set.
    task automatic send_text();
        int burst;
        int gap;
        burst = 0;
        while (text_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                gap   = tx_gaps ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= text_q.pop_front();
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            burst--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Wait for every expected word, then let the pipeline settle for bytes with no output.
    task automatic wait_idle();
        while (utf16_check.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input bit [15:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        bit [7:0]  directed[25];
        bit [15:0] cap_list[8];

        // ASCII, 3- and 4-byte sequences, overlong, surrogate, beyond U+10FFFF,
        // stray continuation, invalid lead FF, sequence broken by ASCII and by NUL
        directed = '{8'h41,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'hC0, 8'h80,
                     8'hED, 8'hA0, 8'h80,
                     8'hF4, 8'h90, 8'h80, 8'h80,
                     8'h80,
                     8'hFF,
                     8'hE2, 8'h41,
                     8'hF0, 8'h9F, 8'h98, 8'h00};
        cap_list = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd0, 16'hFFFF};
        cap_list[6] = 16'($urandom_range(5, 40));

        utf16_check = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed bytes at the reset capacity, clean handshakes.
        foreach (directed[i]) text_q.push_back(directed[i]);
        send_text();
        wait_idle();

        // Random text at the reset capacity with idling on both sides.
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        add_text(20, 1'($urandom_range(0, 1)));
        send_text();
        wait_idle();

        // Sweep the capacity, zero and full range included.
        foreach (cap_list[i]) begin
            write_capacity(cap_list[i]);
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            tx_gaps = ($urandom_range(0, 3) != 0);
            add_text(23, 1'($urandom_range(0, 1)));
            send_text();
            wait_idle();
        end

        utf16_check.drain();
        if (utf16_check.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
